// ===== hdl/acc_pkg.sv =====
// Package: types, constants and digit functions for the alarm clock controller.
`timescale 1ns / 1ps
`default_nettype none
package acc_pkg;

    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [4:0] HOUR_MAX = 5'd23;

    localparam logic [1:0] MODE_RUN   = 2'd0;
    localparam logic [1:0] MODE_CLOCK = 2'd1;
    localparam logic [1:0] MODE_ALARM = 2'd2;

    localparam logic CFG_DEBOUNCE_RELOAD  = 1'b0;
    localparam logic CFG_TICKS_PER_SECOND = 1'b1;

    localparam logic [3:0] DEBOUNCE_RESET = 4'd2;
    localparam logic [3:0] TPS_RESET      = 4'd4;

    localparam logic [6:0] SEG_BLANK = 7'b1111111;

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
    } t_hm;

    typedef struct packed {
        logic [6:0] seg_minute_ones;
        logic [6:0] seg_minute_tens;
        logic [6:0] seg_hour_ones;
        logic [6:0] seg_hour_tens;
        logic       buzzer_on;
        logic [1:0] mode_now;
        logic [1:0] digit_selected;
        logic       alarm_armed;
    } t_result;

    function automatic logic [6:0] seg_of(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'b1000000;
            4'd1:    s = 7'b1111001;
            4'd2:    s = 7'b0100100;
            4'd3:    s = 7'b0110000;
            4'd4:    s = 7'b0011001;
            4'd5:    s = 7'b0010010;
            4'd6:    s = 7'b0000010;
            4'd7:    s = 7'b1111000;
            4'd8:    s = 7'b0000000;
            4'd9:    s = 7'b0010000;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Split a value below 60 into tens and ones.
    function automatic logic [7:0] split_bcd(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] base;
        logic [5:0] ones;
        if (v >= 6'd50) begin
            tens = 4'd5; base = 6'd50;
        end else if (v >= 6'd40) begin
            tens = 4'd4; base = 6'd40;
        end else if (v >= 6'd30) begin
            tens = 4'd3; base = 6'd30;
        end else if (v >= 6'd20) begin
            tens = 4'd2; base = 6'd20;
        end else if (v >= 6'd10) begin
            tens = 4'd1; base = 6'd10;
        end else begin
            tens = 4'd0; base = 6'd0;
        end
        ones = v - base;
        return {tens, ones[3:0]};
    endfunction

    function automatic logic [4:0] hour_inc(input logic [4:0] h);
        return (h == HOUR_MAX) ? 5'd0 : h + 5'd1;
    endfunction

    function automatic logic [4:0] hour_dec(input logic [4:0] h);
        return (h == 5'd0) ? HOUR_MAX : h - 5'd1;
    endfunction

    function automatic t_hm minute_roll(input t_hm t);
        t_hm r;
        r = t;
        if (t.minute == MIN_MAX) begin
            r.minute = 6'd0;
            r.hour   = hour_inc(t.hour);
        end else begin
            r.minute = t.minute + 6'd1;
        end
        return r;
    endfunction

    function automatic t_hm step_digit(input t_hm t, input logic [1:0] digit,
                                       input logic down);
        t_hm r;
        r = t;
        case (digit)
            2'd0: begin
                if (!down) begin
                    r = minute_roll(t);
                end else if (t.minute == 6'd0) begin
                    r.minute = MIN_MAX;
                    r.hour   = hour_dec(t.hour);
                end else begin
                    r.minute = t.minute - 6'd1;
                end
            end
            2'd1: begin
                if (!down) begin
                    if (t.minute >= 6'd50) begin
                        r.minute = 6'd0;
                        r.hour   = hour_inc(t.hour);
                    end else begin
                        r.minute = t.minute + 6'd10;
                    end
                end else if (t.minute < 6'd10) begin
                    r.minute = MIN_MAX;
                    r.hour   = hour_dec(t.hour);
                end else begin
                    r.minute = t.minute - 6'd10;
                end
            end
            2'd2: begin
                r.hour = down ? hour_dec(t.hour) : hour_inc(t.hour);
            end
            default: begin
                if (!down) begin
                    r.hour = (t.hour >= 5'd14) ? 5'd0 : t.hour + 5'd10;
                end else begin
                    r.hour = (t.hour < 5'd10) ? HOUR_MAX : t.hour - 5'd10;
                end
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/acc_in_if.sv =====
// Interface: input sample channel of the alarm clock controller.
`timescale 1ns / 1ps
`default_nettype none
interface acc_in_if;
    logic       valid;
    logic       ready;
    logic       tick;
    logic [3:0] buttons_n;
    logic       alarm_switch;

    modport source (output valid, output tick, output buttons_n, output alarm_switch,
                    input ready);
    modport sink (input valid, input tick, input buttons_n, input alarm_switch,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/acc_out_if.sv =====
// Interface: display and status result channel of the alarm clock controller.
`timescale 1ns / 1ps
`default_nettype none
interface acc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] seg_minute_ones;
    logic [6:0] seg_minute_tens;
    logic [6:0] seg_hour_ones;
    logic [6:0] seg_hour_tens;
    logic       buzzer_on;
    logic [1:0] mode_now;
    logic [1:0] digit_selected;
    logic       alarm_armed;

    modport source (output valid, output seg_minute_ones, output seg_minute_tens,
                    output seg_hour_ones, output seg_hour_tens, output buzzer_on,
                    output mode_now, output digit_selected, output alarm_armed,
                    input ready);
    modport sink (input valid, input seg_minute_ones, input seg_minute_tens,
                  input seg_hour_ones, input seg_hour_tens, input buzzer_on,
                  input mode_now, input digit_selected, input alarm_armed,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/alarm_clock_controller.sv =====
// Top level: alarm clock controller with time keeping, setting modes and display.
//
//  channel   | direction | contents
//  ----------+-----------+-------------------------------------------------
//  i_in      | in        | tick, buttons_n, alarm_switch (one sample)
//  o_out     | out       | four segment codes, buzzer, mode, digit, armed
//  i_cfg_*   | in        | write enable, index, 4-bit data (no read-back)
//
//  State updates at the accepting edge; the result goes to the output register,
//  or to the skid register while o_out stalls. One transaction per clock is kept
//  while o_out.ready stays high; the output and skid registers decouple the sides,
//  and i_in.ready drops only while the skid register holds a result.
//  Reset is synchronous, active low; it loads the default configuration.
`timescale 1ns / 1ps
`default_nettype none
module alarm_clock_controller (
    input  wire        i_clk,
    input  wire        i_rst_n,
    acc_in_if.sink     i_in,
    acc_out_if.source  o_out,
    input  wire        i_cfg_we,
    input  wire        i_cfg_index,
    input  wire [3:0]  i_cfg_data
);
    import acc_pkg::*;

    logic [3:0] r_debounce_reload;
    logic [3:0] r_ticks_per_second;
    logic [3:0] r_tick_phase,   n_tick_phase;
    logic [5:0] r_second_count, n_second_count;
    t_hm        r_time,         n_time;
    t_hm        r_alarm,        n_alarm;
    logic [3:0] r_debounce_left, n_debounce_left;
    logic [1:0] r_digit_index,  n_digit_index;
    logic [1:0] r_mode,         n_mode;
    logic       r_armed_flag,   n_armed_flag;
    logic       r_buzzer_flag,  n_buzzer_flag;

    t_result    r_out, r_skid, n_result;
    logic       r_out_valid, r_skid_valid;
    logic       in_fire, out_fire;

    logic       up, down, next, setb;
    logic [4:0] phase_inc;
    t_hm        disp;
    logic [7:0] disp_min_bcd;
    logic [7:0] disp_hour_bcd;

    assign i_in.ready = !r_skid_valid;
    assign in_fire    = i_in.valid && !r_skid_valid;
    assign out_fire   = r_out_valid && o_out.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_reload  <= DEBOUNCE_RESET;
            r_ticks_per_second <= TPS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE_RELOAD:  r_debounce_reload  <= i_cfg_data;
                CFG_TICKS_PER_SECOND: r_ticks_per_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        up   = !i_in.buttons_n[0];
        down = !i_in.buttons_n[1];
        next = !i_in.buttons_n[2];
        setb = !i_in.buttons_n[3];

        n_tick_phase    = r_tick_phase;
        n_second_count  = r_second_count;
        n_time          = r_time;
        n_alarm         = r_alarm;
        n_debounce_left = r_debounce_left;
        n_digit_index   = r_digit_index;
        n_mode          = r_mode;
        n_armed_flag    = r_armed_flag;
        n_buzzer_flag   = r_buzzer_flag;
        phase_inc       = {1'b0, r_tick_phase} + 5'd1;

        if (i_in.tick) begin
            if (r_tick_phase == 4'd0) begin
                if (r_second_count == MIN_MAX) begin
                    n_second_count = 6'd0;
                    n_time         = minute_roll(r_time);
                    if (r_armed_flag && n_time == r_alarm) begin
                        n_buzzer_flag = 1'b1;
                    end
                end else begin
                    n_second_count = r_second_count + 6'd1;
                end
            end
            n_tick_phase = (phase_inc >= {1'b0, r_ticks_per_second}) ? 4'd0
                                                                      : phase_inc[3:0];
            if (r_debounce_left != 4'd0) begin
                n_debounce_left = r_debounce_left - 4'd1;
            end
        end

        if (n_debounce_left == 4'd0) begin
            unique case (r_mode)
                MODE_CLOCK, MODE_ALARM: begin
                    if (setb) begin
                        n_debounce_left = r_debounce_reload;
                        n_digit_index   = 2'd0;
                        n_mode = (r_mode == MODE_CLOCK && r_armed_flag) ? MODE_ALARM
                                                                         : MODE_RUN;
                    end else if (next) begin
                        n_digit_index   = r_digit_index + 2'd1;
                        n_debounce_left = r_debounce_reload;
                    end else if (down || up) begin
                        if (r_mode == MODE_CLOCK) begin
                            n_time = step_digit(n_time, r_digit_index, down);
                        end else begin
                            n_alarm = step_digit(r_alarm, r_digit_index, down);
                        end
                        n_debounce_left = r_debounce_reload;
                    end
                end
                default: begin
                    if (setb) begin
                        n_debounce_left = r_debounce_reload;
                        n_digit_index   = 2'd0;
                        n_mode          = MODE_CLOCK;
                    end else if (i_in.alarm_switch) begin
                        if (!r_armed_flag) begin
                            n_alarm       = n_time;
                            n_armed_flag  = 1'b1;
                            n_digit_index = 2'd0;
                            n_mode        = MODE_ALARM;
                        end
                    end else begin
                        n_armed_flag  = 1'b0;
                        n_buzzer_flag = 1'b0;
                    end
                end
            endcase
        end

        disp          = (n_mode == MODE_ALARM) ? n_alarm : n_time;
        disp_min_bcd  = split_bcd(disp.minute);
        disp_hour_bcd = split_bcd({1'b0, disp.hour});

        n_result.seg_minute_ones = seg_of(disp_min_bcd[3:0]);
        n_result.seg_minute_tens = seg_of(disp_min_bcd[7:4]);
        n_result.seg_hour_ones   = seg_of(disp_hour_bcd[3:0]);
        n_result.seg_hour_tens   = seg_of(disp_hour_bcd[7:4]);
        n_result.buzzer_on       = n_buzzer_flag;
        n_result.mode_now        = n_mode;
        n_result.digit_selected  = n_digit_index;
        n_result.alarm_armed     = n_armed_flag;
    end

    // Clock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_phase    <= 4'd0;
            r_second_count  <= 6'd0;
            r_time          <= '0;
            r_alarm         <= '0;
            r_debounce_left <= 4'd0;
            r_digit_index   <= 2'd0;
            r_mode          <= MODE_RUN;
            r_armed_flag    <= 1'b0;
            r_buzzer_flag   <= 1'b0;
        end else if (in_fire) begin
            r_tick_phase    <= n_tick_phase;
            r_second_count  <= n_second_count;
            r_time          <= n_time;
            r_alarm         <= n_alarm;
            r_debounce_left <= n_debounce_left;
            r_digit_index   <= n_digit_index;
            r_mode          <= n_mode;
            r_armed_flag    <= n_armed_flag;
            r_buzzer_flag   <= n_buzzer_flag;
        end
    end

    // Output and skid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid && !o_out.ready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && !o_out.ready) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.seg_minute_ones = r_out.seg_minute_ones;
    assign o_out.seg_minute_tens = r_out.seg_minute_tens;
    assign o_out.seg_hour_ones   = r_out.seg_hour_ones;
    assign o_out.seg_hour_tens   = r_out.seg_hour_tens;
    assign o_out.buzzer_on       = r_out.buzzer_on;
    assign o_out.mode_now        = r_out.mode_now;
    assign o_out.digit_selected  = r_out.digit_selected;
    assign o_out.alarm_armed     = r_out.alarm_armed;

`ifndef SYNTH
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_time.minute <= MIN_MAX && r_time.hour <= HOUR_MAX &&
        r_alarm.minute <= MIN_MAX && r_alarm.hour <= HOUR_MAX &&
        r_second_count <= MIN_MAX)
        else $error("time or alarm counter out of range");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("transaction accepted under stall was not parked in skid");

    a_buzzer_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_buzzer_flag) |-> r_armed_flag)
        else $error("buzzer set while alarm not armed");
`endif
endmodule
`default_nettype wire

// ===== test/acc_checker.sv =====
// Checker: predicts every displayed result of the alarm clock controller and compares it.
`timescale 1ns / 1ps
module acc_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acc_in_if          i_in,
    acc_out_if         i_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    import acc_pkg::*;

    localparam int MINUTES_PER_HOUR = 60;
    localparam int HOURS_PER_DAY    = 24;
    localparam int LAST_MINUTE      = 59;
    localparam int LAST_SECOND      = 59;
    localparam int REPORT_LIMIT     = 10;

    localparam logic [1:0] DIG_MIN_ONES  = 2'd0;
    localparam logic [1:0] DIG_MIN_TENS  = 2'd1;
    localparam logic [1:0] DIG_HOUR_ONES = 2'd2;

    logic [3:0] cfg_debounce;
    logic [3:0] cfg_tps;
    logic [3:0] tick_phase;
    logic [3:0] debounce_left;
    logic [5:0] seconds;
    t_hm        clock_hm;
    t_hm        alarm_hm;
    logic [1:0] digit;
    logic [1:0] mode;
    logic       armed;
    logic       buzzing;
    t_result    display_q[$];
    int         fails = 0;

    function automatic t_hm wrap_hm(input int m, input int h);
        t_hm r;
        if (m >= MINUTES_PER_HOUR) begin
            h++;
            m = 0;
        end else if (m < 0) begin
            h--;
            m = LAST_MINUTE;
        end
        if (h >= HOURS_PER_DAY) begin
            h = 0;
        end else if (h < 0) begin
            h = HOURS_PER_DAY - 1;
        end
        r.minute = m[5:0];
        r.hour   = h[4:0];
        return r;
    endfunction

    function automatic t_hm nudge(input t_hm t, input logic [1:0] sel, input logic down);
        int step;
        int m;
        int h;
        step = down ? -1 : 1;
        m = int'(t.minute);
        h = int'(t.hour);
        case (sel)
            DIG_MIN_ONES:  m += step;
            DIG_MIN_TENS:  m += 10 * step;
            DIG_HOUR_ONES: h += step;
            default:       h += 10 * step;
        endcase
        return wrap_hm(m, h);
    endfunction

    function automatic logic [6:0] seg_pattern(input int d);
        case (d)
            0:       return 7'b1000000;
            1:       return 7'b1111001;
            2:       return 7'b0100100;
            3:       return 7'b0110000;
            4:       return 7'b0011001;
            5:       return 7'b0010010;
            6:       return 7'b0000010;
            7:       return 7'b1111000;
            8:       return 7'b0000000;
            9:       return 7'b0010000;
            default: return SEG_BLANK;
        endcase
    endfunction

    function automatic t_result shown();
        t_result r;
        t_hm     v;
        int      m;
        int      h;
        v = (mode == MODE_ALARM) ? alarm_hm : clock_hm;
        m = int'(v.minute);
        h = int'(v.hour);
        r.seg_minute_ones = seg_pattern(m % 10);
        r.seg_minute_tens = seg_pattern(m / 10);
        r.seg_hour_ones   = seg_pattern(h % 10);
        r.seg_hour_tens   = seg_pattern(h / 10);
        r.buzzer_on       = buzzing;
        r.mode_now        = mode;
        r.digit_selected  = digit;
        r.alarm_armed     = armed;
        return r;
    endfunction

    task automatic clear_state();
        cfg_debounce  = DEBOUNCE_RESET;
        cfg_tps       = TPS_RESET;
        tick_phase    = '0;
        debounce_left = '0;
        seconds       = '0;
        clock_hm      = '0;
        alarm_hm      = '0;
        digit         = '0;
        mode          = MODE_RUN;
        armed         = 1'b0;
        buzzing       = 1'b0;
    endtask

    task automatic advance(input logic tick, input logic [3:0] btn_n, input logic sw);
        logic up;
        logic dn;
        logic nx;
        logic st;
        up = !btn_n[0];
        dn = !btn_n[1];
        nx = !btn_n[2];
        st = !btn_n[3];

        if (tick) begin
            if (tick_phase == 4'd0) begin
                if (int'(seconds) == LAST_SECOND) begin
                    seconds  = '0;
                    clock_hm = wrap_hm(int'(clock_hm.minute) + 1, int'(clock_hm.hour));
                    if (armed && clock_hm == alarm_hm) begin
                        buzzing = 1'b1;
                    end
                end else begin
                    seconds = seconds + 6'd1;
                end
            end
            if (int'(tick_phase) + 1 >= int'(cfg_tps)) begin
                tick_phase = '0;
            end else begin
                tick_phase = tick_phase + 4'd1;
            end
            if (debounce_left != 4'd0) begin
                debounce_left = debounce_left - 4'd1;
            end
        end

        if (debounce_left == 4'd0) begin
            if (mode == MODE_CLOCK || mode == MODE_ALARM) begin
                if (st) begin
                    debounce_left = cfg_debounce;
                    digit         = '0;
                    mode          = (mode == MODE_CLOCK && armed) ? MODE_ALARM : MODE_RUN;
                end else if (nx) begin
                    digit         = digit + 2'd1;
                    debounce_left = cfg_debounce;
                end else if (dn || up) begin
                    if (mode == MODE_CLOCK) begin
                        clock_hm = nudge(clock_hm, digit, dn);
                    end else begin
                        alarm_hm = nudge(alarm_hm, digit, dn);
                    end
                    debounce_left = cfg_debounce;
                end
            end else begin
                if (st) begin
                    debounce_left = cfg_debounce;
                    digit         = '0;
                    mode          = MODE_CLOCK;
                end else if (sw) begin
                    if (!armed) begin
                        alarm_hm = clock_hm;
                        armed    = 1'b1;
                        digit    = '0;
                        mode     = MODE_ALARM;
                    end
                end else begin
                    armed   = 1'b0;
                    buzzing = 1'b0;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_state();
            display_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DEBOUNCE_RELOAD) begin
                    cfg_debounce = i_cfg_data;
                end else begin
                    cfg_tps = i_cfg_data;
                end
            end
            if (i_out.valid && i_out.ready) begin
                got.seg_minute_ones = i_out.seg_minute_ones;
                got.seg_minute_tens = i_out.seg_minute_tens;
                got.seg_hour_ones   = i_out.seg_hour_ones;
                got.seg_hour_tens   = i_out.seg_hour_tens;
                got.buzzer_on       = i_out.buzzer_on;
                got.mode_now        = i_out.mode_now;
                got.digit_selected  = i_out.digit_selected;
                got.alarm_armed     = i_out.alarm_armed;
                if (display_q.size() == 0) begin
                    if (fails < REPORT_LIMIT) begin
                        $display("acc_checker: unexpected result %h at %0t", got, $realtime);
                    end
                    fails++;
                end else begin
                    want = display_q.pop_front();
                    if (got !== want) begin
                        if (fails < REPORT_LIMIT) begin
                            $display("acc_checker: mismatch at %0t", $realtime);
                            $display("  expected seg %h %h %h %h buzzer %b mode %0d digit %0d armed %b",
                                     want.seg_minute_ones, want.seg_minute_tens,
                                     want.seg_hour_ones, want.seg_hour_tens, want.buzzer_on,
                                     want.mode_now, want.digit_selected, want.alarm_armed);
                            $display("  actual   seg %h %h %h %h buzzer %b mode %0d digit %0d armed %b",
                                     got.seg_minute_ones, got.seg_minute_tens,
                                     got.seg_hour_ones, got.seg_hour_tens, got.buzzer_on,
                                     got.mode_now, got.digit_selected, got.alarm_armed);
                        end
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                advance(i_in.tick, i_in.buttons_n, i_in.alarm_switch);
                display_q.push_back(shown());
            end
        end
        o_pending    <= display_q.size();
        o_fail_count <= fails;
    end
endmodule

// ===== test/tb_alarm_clock_controller.sv =====
// Testbench top: drives samples and register writes into the alarm clock controller.
`timescale 1ns / 1ps
module tb_alarm_clock_controller;
    import acc_pkg::*;

    localparam logic [3:0] BTN_NONE = 4'b1111;
    localparam logic [3:0] BTN_UP   = 4'b1110;
    localparam logic [3:0] BTN_DOWN = 4'b1101;
    localparam logic [3:0] BTN_NEXT = 4'b1011;
    localparam logic [3:0] BTN_SET  = 4'b0111;
    localparam logic [3:0] BTN_ALL  = 4'b0000;

    localparam int MAX_IDLE           = 10;
    localparam int LONG_HOLD          = 60;
    localparam int SETTLE_CYCLES      = 4;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int PHASE_ITEMS        = 60;
    localparam int NUM_PHASES         = 7;
    localparam int SECONDS_PER_MINUTE = 60;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_data;
    int         fail_count;
    int         pending;
    int         cycles = 0;
    int         sent = 0;
    logic       src_idle_on = 1'b1;
    logic       sink_idle_on = 1'b1;
    logic       hold_long = 1'b0;
    logic       sw_level = 1'b0;
    logic [1:0] last_mode = MODE_RUN;
    logic [3:0] cur_deb = DEBOUNCE_RESET;
    logic [3:0] cur_tps = TPS_RESET;
    logic [3:0] phase_deb [NUM_PHASES] = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd3, 4'd0, 4'd7};
    logic [3:0] phase_tps [NUM_PHASES] = '{4'd1, 4'd0, 4'd15, 4'd4, 4'd2, 4'd1, 4'd0};

    acc_in_if  in_ch ();
    acc_out_if out_ch ();

    alarm_clock_controller u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    acc_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_alarm_clock_controller: FAIL");
            $finish;
        end
    end

    initial begin : result_sink
        int stall;
        out_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            stall = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            last_mode = out_ch.mode_now;
            @(negedge clk);
        end
    end

    task automatic send(input logic tick, input logic [3:0] btn_n, input logic sw);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.tick         <= tick;
        in_ch.buttons_n    <= btn_n;
        in_ch.alarm_switch <= sw;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        sent++;
    endtask

    // Press, then release with enough ticks to run out the debounce.
    task automatic press(input logic [3:0] btn_n, input logic sw);
        send(1'($urandom_range(0, 1)), btn_n, sw);
        repeat (cur_deb) send(1'b1, BTN_NONE, sw);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == CFG_DEBOUNCE_RELOAD) begin
            cur_deb = val;
        end else begin
            cur_tps = val;
        end
    endtask

    initial begin : stimulus
        int         action;
        int         target;
        logic [3:0] btn;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_DEBOUNCE_RELOAD;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.tick         = 1'b0;
        in_ch.buttons_n    = BTN_NONE;
        in_ch.alarm_switch = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_reg(CFG_DEBOUNCE_RELOAD, 4'd1);
        send(1'b0, BTN_NONE, 1'b0);
        send(1'b1, BTN_ALL, 1'b1);
        send(1'b1, BTN_NONE, 1'b1);
        press(BTN_DOWN, 1'b0);
        press(BTN_UP, 1'b0);
        press(BTN_NEXT, 1'b0);
        press(BTN_DOWN, 1'b0);
        press(BTN_NEXT & BTN_DOWN, 1'b0);
        press(BTN_DOWN & BTN_UP, 1'b0);
        press(BTN_NEXT, 1'b0);
        press(BTN_UP, 1'b0);
        press(BTN_DOWN, 1'b0);
        send(1'b1, BTN_SET, 1'b0);
        send(1'b1, BTN_NONE, 1'b1);
        press(BTN_DOWN, 1'b1);
        send(1'b0, BTN_SET, 1'b1);
        send(1'b1, BTN_SET, 1'b1);
        send(1'b1, BTN_NONE, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_reg(CFG_DEBOUNCE_RELOAD, phase_deb[p]);
            write_reg(CFG_TICKS_PER_SECOND, phase_tps[p]);
            src_idle_on  = (p % 3 == 0);
            sink_idle_on = (p % 3 != 1);
            if (p == 2) begin
                hold_long = 1'b1;
            end
            target = sent + PHASE_ITEMS;
            while (sent < target) begin
                action = $urandom_range(0, 9);
                if (action <= 5) begin
                    case ($urandom_range(0, 3))
                        0:       btn = BTN_UP;
                        1:       btn = BTN_DOWN;
                        2:       btn = BTN_NEXT;
                        default: btn = BTN_SET;
                    endcase
                    if ($urandom_range(0, 3) == 0) begin
                        btn = btn & 4'($urandom);
                    end
                    press(btn, sw_level);
                end else if (action == 6) begin
                    sw_level = !sw_level;
                    send(1'($urandom_range(0, 1)), BTN_NONE, sw_level);
                end else if (action == 7) begin
                    repeat ($urandom_range(5, 40)) send(1'b1, BTN_NONE, sw_level);
                end else begin
                    send(1'($urandom_range(0, 1)), 4'($urandom), 1'($urandom_range(0, 1)));
                end
            end

            // Arm one minute ahead and run the clock into the alarm.
            if (p == 0 || p == 1 || p == 4) begin
                drain();
                repeat (cur_deb) send(1'b1, BTN_NONE, sw_level);
                drain();
                repeat (3) begin
                    if (last_mode != MODE_RUN) begin
                        press(BTN_SET, 1'b1);
                        drain();
                    end
                end
                send(1'b1, BTN_NONE, 1'b0);
                send(1'b0, BTN_NONE, 1'b1);
                press(BTN_UP, 1'b1);
                press(BTN_SET, 1'b1);
                repeat ((SECONDS_PER_MINUTE + 1) * (cur_tps == 4'd0 ? 1 : int'(cur_tps)))
                    send(1'b1, BTN_NONE, 1'b1);
                send(1'b1, BTN_NONE, 1'b0);
                sw_level = 1'b0;
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("tb_alarm_clock_controller: PASS");
        end else begin
            $display("tb_alarm_clock_controller: FAIL");
        end
        $finish;
    end
endmodule

// ===== alarm_clock_controller.f =====
hdl/acc_pkg.sv
hdl/acc_in_if.sv
hdl/acc_out_if.sv
hdl/alarm_clock_controller.sv
test/acc_checker.sv
test/tb_alarm_clock_controller.sv
